// ----- design/mvmu_pkg.sv -----
// Masked vector math unit: shared package.
// Widths, codes, pipeline payload structs. No dependencies.
package mvmu_pkg;

  localparam int DATA_W        = 32;
  localparam int LANES         = 4;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_WIDTH_DEF = 4;
  localparam int MIN_WIDTH     = 2;
  localparam int VW_W          = 3;
  localparam int OP_W          = DATA_W + 1;
  localparam int PROD_W        = 2 * OP_W;
  localparam int SQ_IN_W       = 64;
  localparam int ROOT_W        = SQ_IN_W / 2;
  localparam int REM_W         = ROOT_W + 2;
  localparam int UN_W          = DATA_W - 1;
  localparam int FRONT_N       = 5;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = VW_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MASK_SENSE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VEC_WIDTH  = 1'b1;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    MODE_DOT   = 2'd0,
    MODE_MAG   = 2'd1,
    MODE_NORM  = 2'd2,
    MODE_CROSS = 2'd3
  } mvmu_mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CROSS_W   = 2'd1,
    ST_ZERO_NORM = 2'd2,
    ST_SAT       = 2'd3
  } mvmu_status_t;

  // front end: abs values, max search and scaling for normalise
  typedef struct packed {
    logic                         valid;
    mvmu_mode_t                   mode;
    logic                         en;
    logic [VW_W-1:0]              w;
    logic [LANES-1:0][DATA_W-1:0] a;
    logic [LANES-1:0][DATA_W-1:0] b;
    logic [LANES-1:0][DATA_W-1:0] u;
    logic [DATA_W-1:0]            mx;
    logic                         big;
    logic                         zero;
    logic [4:0]                   sh;
    logic [LANES-1:0][UN_W-1:0]   un;
  } front_t;

  // back end: what travels alongside the root and divider pipes
  typedef struct packed {
    logic                         valid;
    mvmu_mode_t                   mode;
    logic                         en;
    logic                         w3;
    logic                         zero;
    logic                         sat;
    logic [LANES-1:0][DATA_W-1:0] res;
    logic [LANES-1:0]             neg;
    logic [LANES-1:0][UN_W-1:0]   un;
  } side_t;

endpackage

// ----- design/mvmu_lane.sv -----
// Masked vector math unit: one lane, two registered signed multipliers.
// Depends on mvmu_pkg.
module mvmu_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [mvmu_pkg::OP_W-1:0]    x1,
  input  logic signed [mvmu_pkg::OP_W-1:0]    y1,
  input  logic signed [mvmu_pkg::OP_W-1:0]    x2,
  input  logic signed [mvmu_pkg::OP_W-1:0]    y2,
  output logic signed [mvmu_pkg::PROD_W-1:0]  p1,
  output logic signed [mvmu_pkg::PROD_W-1:0]  p2
);
  import mvmu_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= x1 * y1;
      p2 <= x2 * y2;
    end
  end

endmodule

// ----- design/mvmu_sqrt.sv -----
// Masked vector math unit: pipelined integer square root, one root bit per stage.
// Depends on mvmu_pkg. Gives floor root and remainder v - root^2.
module mvmu_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [mvmu_pkg::SQ_IN_W-1:0]  v,
  output logic [mvmu_pkg::ROOT_W-1:0]   root,
  output logic [mvmu_pkg::REM_W-1:0]    rem
);
  import mvmu_pkg::*;

  logic [SQ_IN_W-1:0] v_r    [ROOT_W];
  logic [ROOT_W-1:0]  root_r [ROOT_W];
  logic [REM_W-1:0]   rem_r  [ROOT_W];
  logic [SQ_IN_W-1:0] v_nxt    [ROOT_W];
  logic [ROOT_W-1:0]  root_nxt [ROOT_W];
  logic [REM_W-1:0]   rem_nxt  [ROOT_W];

  always_comb begin
    logic [SQ_IN_W-1:0] vs;
    logic [ROOT_W-1:0]  rs;
    logic [REM_W-1:0]   ms;
    logic [REM_W+1:0]   rem2;
    logic [REM_W+1:0]   trial;
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        vs = v;
        rs = '0;
        ms = '0;
      end else begin
        vs = v_r[k-1];
        rs = root_r[k-1];
        ms = rem_r[k-1];
      end
      rem2  = {ms, vs[2*(ROOT_W-1-k) +: 2]};
      trial = {2'b00, rs, 2'b01};
      v_nxt[k] = vs;
      if (rem2 >= trial) begin
        rem_nxt[k]  = REM_W'(rem2 - trial);
        root_nxt[k] = {rs[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem2[REM_W-1:0];
        root_nxt[k] = {rs[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r    <= v_nxt;
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign root = root_r[ROOT_W-1];
  assign rem  = rem_r[ROOT_W-1];

endmodule

// ----- design/mvmu_div.sv -----
// Masked vector math unit: pipelined restoring divider for one lane.
// Depends on mvmu_pkg. q = (u * 2^FRAC_BITS + m/2) / m, q below 2^(FRAC_BITS+1).
module mvmu_div #(
  parameter int FRAC_BITS = mvmu_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [mvmu_pkg::UN_W-1:0]   u,
  input  logic [mvmu_pkg::ROOT_W-1:0] m,
  output logic [FRAC_BITS:0]          q
);
  import mvmu_pkg::*;

  localparam int QB = FRAC_BITS + 1;
  localparam int NW = UN_W + FRAC_BITS + 1;

  logic [NW-1:0]     n;
  logic [ROOT_W-1:0] rem_r [QB];
  logic [NW-1:0]     n_r   [QB];
  logic [ROOT_W-1:0] m_r   [QB];
  logic [QB-1:0]     q_r   [QB];
  logic [ROOT_W-1:0] rem_nxt [QB];
  logic [NW-1:0]     n_nxt   [QB];
  logic [ROOT_W-1:0] m_nxt   [QB];
  logic [QB-1:0]     q_nxt   [QB];

  assign n = (NW'(u) << FRAC_BITS) + NW'(m >> 1);

  always_comb begin
    logic [ROOT_W-1:0] rs;
    logic [NW-1:0]     ns;
    logic [ROOT_W-1:0] ms;
    logic [QB-1:0]     qs;
    logic [ROOT_W:0]   rem2;
    for (int k = 0; k < QB; k++) begin
      if (k == 0) begin
        rs = ROOT_W'(n[NW-1:QB]);
        ns = n;
        ms = m;
        qs = '0;
      end else begin
        rs = rem_r[k-1];
        ns = n_r[k-1];
        ms = m_r[k-1];
        qs = q_r[k-1];
      end
      rem2     = {rs, ns[QB-1-k]};
      n_nxt[k] = ns;
      m_nxt[k] = ms;
      if (rem2 >= {1'b0, ms}) begin
        rem_nxt[k] = ROOT_W'(rem2 - {1'b0, ms});
        q_nxt[k]   = {qs[QB-2:0], 1'b1};
      end else begin
        rem_nxt[k] = rem2[ROOT_W-1:0];
        q_nxt[k]   = {qs[QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      n_r   <= n_nxt;
      m_r   <= m_nxt;
      q_r   <= q_nxt;
    end
  end

  assign q = q_r[QB-1];

endmodule

// ----- design/masked_vector_math_unit.sv -----
// Masked vector math unit: top level. Front end, four multiplier lanes, merge and
// rounding, root pipe, per-lane divider pipes, output register.
// Depends on mvmu_pkg, mvmu_lane, mvmu_sqrt, mvmu_div.
//
// Usage:
//  - Input channel in_*: one word per cycle when in_valid is high and in_stall low.
//    Each word is two vectors (a, b), a mode and a mask bit.
//  - Output channel out_*: exactly one result word per input word, in order.
//  - Config port cfg_*: register 0 is mask_sense, register 1 is vector_width.
//    Write only with the unit empty.
//  - Depth: the path from acceptance to out_valid is the same for every mode.
//    It is set by the root pipe (one root bit per stage, 32 stages) and the
//    divider pipes (FRAC_BITS + 1 stages, FRAC_BITS = 16 at Q16.16).
//  - Throughput: one word per cycle, sustained while out_stall holds no valid word.
//  - Stall: the whole pipe advances as one. A held output word freezes every stage,
//    so in_stall rises in the same cycle that out_stall holds a valid word.
//  - Reset (rst_n low, synchronous): all stage valids and out_valid clear,
//    mask_sense goes to 1, vector_width to 3.
//  - vector_width is clamped to 2..MAX_WIDTH. Lanes beyond it read as zero.
module masked_vector_math_unit #(
  parameter int FRAC_BITS = mvmu_pkg::FRAC_BITS_DEF,
  parameter int MAX_WIDTH = mvmu_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_mode,
  input  logic signed [31:0]               in_a_x,
  input  logic signed [31:0]               in_a_y,
  input  logic signed [31:0]               in_a_z,
  input  logic signed [31:0]               in_a_w,
  input  logic signed [31:0]               in_b_x,
  input  logic signed [31:0]               in_b_y,
  input  logic signed [31:0]               in_b_z,
  input  logic signed [31:0]               in_b_w,
  input  logic                             in_mask_bit,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [31:0]               out_r_x,
  output logic signed [31:0]               out_r_y,
  output logic signed [31:0]               out_r_z,
  output logic signed [31:0]               out_r_w,
  output logic                             out_written,
  output logic [1:0]                       out_status,
  // configuration
  input  logic                             cfg_we,
  input  logic [mvmu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mvmu_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mvmu_pkg::*;

  localparam int QB = FRAC_BITS + 1;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic            mask_sense_r;
  logic [VW_W-1:0] vector_width_r;
  logic [VW_W-1:0] w_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_sense_r   <= 1'b1;
      vector_width_r <= 3'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MASK_SENSE: mask_sense_r   <= cfg_wdata[0];
        CFG_VEC_WIDTH:  vector_width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp to the supported range
  assign w_eff = (vector_width_r < VW_W'(MIN_WIDTH)) ? VW_W'(MIN_WIDTH) :
                 (vector_width_r > VW_W'(MAX_WIDTH)) ? VW_W'(MAX_WIDTH) :
                 vector_width_r;

  // ---------------------------------------------------------------------------
  // Flow control: one enable for the whole pipe
  // ---------------------------------------------------------------------------
  logic adv;
  logic out_valid_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // ---------------------------------------------------------------------------
  // Front end
  //  0: capture, 1: abs + lane gating, 2: max, 3: shift amount, 4: scale
  // ---------------------------------------------------------------------------
  front_t fr_r   [FRONT_N];
  front_t fr_nxt [FRONT_N];

  always_comb begin
    logic [DATA_W-1:0] m01;
    logic [DATA_W-1:0] m23;
    logic [DATA_W-1:0] shl;
    shl = '0;
    // capture
    fr_nxt[0]       = '0;
    fr_nxt[0].valid = in_valid;
    fr_nxt[0].mode  = mvmu_mode_t'(in_mode);
    fr_nxt[0].en    = (in_mask_bit == mask_sense_r);
    fr_nxt[0].w     = w_eff;
    fr_nxt[0].a     = {in_a_w, in_a_z, in_a_y, in_a_x};
    fr_nxt[0].b     = {in_b_w, in_b_z, in_b_y, in_b_x};
    // magnitudes of the lanes in use; -2^31 gives 2^31 unsigned
    fr_nxt[1] = fr_r[0];
    for (int i = 0; i < LANES; i++) begin
      if (VW_W'(i) < fr_r[0].w) begin
        fr_nxt[1].u[i] = fr_r[0].a[i][DATA_W-1] ? (~fr_r[0].a[i] + 1'b1) : fr_r[0].a[i];
      end else begin
        fr_nxt[1].u[i] = '0;
      end
    end
    // largest magnitude
    fr_nxt[2]    = fr_r[1];
    m01          = (fr_r[1].u[0] > fr_r[1].u[1]) ? fr_r[1].u[0] : fr_r[1].u[1];
    m23          = (fr_r[1].u[2] > fr_r[1].u[3]) ? fr_r[1].u[2] : fr_r[1].u[3];
    fr_nxt[2].mx = (m01 > m23) ? m01 : m23;
    // scale: halve when at or above 2^30, else shift up into [2^29, 2^30)
    fr_nxt[3]      = fr_r[2];
    fr_nxt[3].big  = fr_r[2].mx[DATA_W-1] | fr_r[2].mx[DATA_W-2];
    fr_nxt[3].zero = (fr_r[2].mx == '0);
    fr_nxt[3].sh   = '0;
    for (int k = 0; k < DATA_W - 2; k++) begin
      if (fr_r[2].mx[k]) begin
        fr_nxt[3].sh = 5'(DATA_W - 3 - k);
      end
    end
    fr_nxt[4] = fr_r[3];
    for (int i = 0; i < LANES; i++) begin
      shl = fr_r[3].big ? (fr_r[3].u[i] >> 1) : (fr_r[3].u[i] << fr_r[3].sh);
      fr_nxt[4].un[i] = shl[UN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Lane operands
  // ---------------------------------------------------------------------------
  logic signed [OP_W-1:0]   op_x1 [LANES];
  logic signed [OP_W-1:0]   op_y1 [LANES];
  logic signed [OP_W-1:0]   op_x2 [LANES];
  logic signed [OP_W-1:0]   op_y2 [LANES];
  logic signed [PROD_W-1:0] p1    [LANES];
  logic signed [PROD_W-1:0] p2    [LANES];

  function automatic logic signed [OP_W-1:0] sx(input logic [DATA_W-1:0] x);
    return {x[DATA_W-1], x};
  endfunction

  always_comb begin
    front_t f;
    f = fr_r[FRONT_N-1];
    for (int i = 0; i < LANES; i++) begin
      op_x1[i] = '0;
      op_y1[i] = '0;
      op_x2[i] = '0;
      op_y2[i] = '0;
      if (VW_W'(i) < f.w) begin
        case (f.mode)
          MODE_DOT: begin
            op_x1[i] = sx(f.a[i]);
            op_y1[i] = sx(f.b[i]);
          end
          MODE_MAG: begin
            op_x1[i] = {1'b0, f.u[i]};
            op_y1[i] = {1'b0, f.u[i]};
          end
          MODE_NORM: begin
            op_x1[i] = {2'b00, f.un[i]};
            op_y1[i] = {2'b00, f.un[i]};
          end
          MODE_CROSS: ;
          default: ;
        endcase
      end
    end
    // cross: lane i forms the two products of component i
    if (f.mode == MODE_CROSS) begin
      op_x1[0] = sx(f.a[1]); op_y1[0] = sx(f.b[2]);
      op_x2[0] = sx(f.a[2]); op_y2[0] = sx(f.b[1]);
      op_x1[1] = sx(f.a[2]); op_y1[1] = sx(f.b[0]);
      op_x2[1] = sx(f.a[0]); op_y2[1] = sx(f.b[2]);
      op_x1[2] = sx(f.a[0]); op_y1[2] = sx(f.b[1]);
      op_x2[2] = sx(f.a[1]); op_y2[2] = sx(f.b[0]);
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mvmu_lane u_lane (
      .clk (clk),
      .en  (adv),
      .x1  (op_x1[g]),
      .y1  (op_y1[g]),
      .x2  (op_x2[g]),
      .y2  (op_y2[g]),
      .p1  (p1[g]),
      .p2  (p2[g])
    );
  end

  function automatic side_t to_side(input front_t f);
    side_t s;
    s       = '0;
    s.valid = f.valid;
    s.mode  = f.mode;
    s.en    = f.en;
    s.w3    = (f.w == 3'd3);
    s.zero  = f.zero;
    s.un    = f.un;
    for (int i = 0; i < LANES; i++) begin
      s.neg[i] = f.a[i][DATA_W-1];
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Merge: lane sum (dot, sum of squares) and per-lane differences (cross)
  // ---------------------------------------------------------------------------
  side_t                    mul_side_r;
  side_t                    mg_side_r;
  logic signed [PROD_W-1:0] mg_sum_r;
  logic signed [PROD_W-1:0] mg_d_r [3];
  logic signed [PROD_W-1:0] mg_sum_nxt;
  logic signed [PROD_W-1:0] mg_d_nxt [3];

  always_comb begin
    mg_sum_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      mg_sum_nxt = mg_sum_nxt + p1[i];
    end
    for (int i = 0; i < 3; i++) begin
      mg_d_nxt[i] = p1[i] - p2[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Round to nearest (ties up) and saturate to 32 bits
  // ---------------------------------------------------------------------------
  function automatic logic [DATA_W:0] round_sat(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    logic                     ovf;
    t   = (v + HALF) >>> FRAC_BITS;
    ovf = !((t[PROD_W-1:DATA_W-1] == '0) || (t[PROD_W-1:DATA_W-1] == '1));
    if (ovf) begin
      return {1'b1, t[PROD_W-1] ? SAT_MIN : SAT_MAX};
    end
    return {1'b0, t[DATA_W-1:0]};
  endfunction

  side_t               rnd_side_r;
  side_t               rnd_side_nxt;
  logic [SQ_IN_W-1:0]  rnd_sq_r;

  always_comb begin
    logic [DATA_W:0] rs;
    rs           = '0;
    rnd_side_nxt = mg_side_r;
    case (mg_side_r.mode)
      MODE_DOT: begin
        rs = round_sat(mg_sum_r);
        rnd_side_nxt.res[0] = rs[DATA_W-1:0];
        rnd_side_nxt.sat    = rs[DATA_W];
      end
      MODE_MAG: begin
        // sum of squares of 2^62 or more cannot give a 31-bit root
        rnd_side_nxt.sat    = |mg_sum_r[PROD_W-1:SQ_IN_W-2];
        rnd_side_nxt.res[0] = SAT_MAX;
      end
      MODE_NORM: ;
      MODE_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          rs = round_sat(mg_d_r[i]);
          rnd_side_nxt.res[i] = rs[DATA_W-1:0];
          if (rs[DATA_W]) begin
            rnd_side_nxt.sat = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Root pipe, then per-lane dividers
  // ---------------------------------------------------------------------------
  side_t             sq_side_r [ROOT_W];
  side_t             dv_side_r [QB];
  side_t             dv_in_side;
  logic [ROOT_W-1:0] sq_root;
  logic [REM_W-1:0]  sq_rem;
  logic [FRAC_BITS:0] dv_q [LANES];

  mvmu_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .v    (rnd_sq_r),
    .root (sq_root),
    .rem  (sq_rem)
  );

  // magnitude: round the root up when the remainder exceeds it
  always_comb begin
    logic [ROOT_W:0] q2;
    dv_in_side = sq_side_r[ROOT_W-1];
    q2 = {1'b0, sq_root} + ROOT_W'(1);
    if (REM_W'(sq_root) >= sq_rem) begin
      q2 = {1'b0, sq_root};
    end
    if (dv_in_side.mode == MODE_MAG && !dv_in_side.sat) begin
      if (q2[ROOT_W:DATA_W-1] != '0) begin
        dv_in_side.sat    = 1'b1;
        dv_in_side.res[0] = SAT_MAX;
      end else begin
        dv_in_side.res[0] = q2[DATA_W-1:0];
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_div
    mvmu_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk (clk),
      .en  (adv),
      .u   (sq_side_r[ROOT_W-1].un[g]),
      .m   (sq_root),
      .q   (dv_q[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Output word
  // ---------------------------------------------------------------------------
  logic [LANES-1:0][DATA_W-1:0] out_r_r;
  logic                         out_written_r;
  mvmu_status_t                 out_status_r;
  logic [LANES-1:0][DATA_W-1:0] out_r_nxt;
  logic                         out_written_nxt;
  mvmu_status_t                 out_status_nxt;

  always_comb begin
    side_t             fs;
    logic [DATA_W-1:0] qe;
    qe              = '0;
    fs              = dv_side_r[QB-1];
    out_r_nxt       = '0;
    out_written_nxt = 1'b0;
    out_status_nxt  = ST_OK;
    if (fs.en) begin
      out_written_nxt = 1'b1;
      case (fs.mode)
        MODE_DOT, MODE_MAG: begin
          out_r_nxt[0]   = fs.res[0];
          out_status_nxt = fs.sat ? ST_SAT : ST_OK;
        end
        MODE_NORM: begin
          if (fs.zero) begin
            out_status_nxt = ST_ZERO_NORM;
          end else begin
            for (int i = 0; i < LANES; i++) begin
              qe           = DATA_W'(dv_q[i]);
              out_r_nxt[i] = fs.neg[i] ? (~qe + 1'b1) : qe;
            end
          end
        end
        MODE_CROSS: begin
          if (!fs.w3) begin
            out_written_nxt = 1'b0;
            out_status_nxt  = ST_CROSS_W;
          end else begin
            out_r_nxt[0]   = fs.res[0];
            out_r_nxt[1]   = fs.res[1];
            out_r_nxt[2]   = fs.res[2];
            out_status_nxt = fs.sat ? ST_SAT : ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipe registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < FRONT_N; k++) begin
        fr_r[k].valid <= 1'b0;
      end
      mul_side_r.valid <= 1'b0;
      mg_side_r.valid  <= 1'b0;
      rnd_side_r.valid <= 1'b0;
      for (int k = 0; k < ROOT_W; k++) begin
        sq_side_r[k].valid <= 1'b0;
      end
      for (int k = 0; k < QB; k++) begin
        dv_side_r[k].valid <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      fr_r       <= fr_nxt;
      mul_side_r <= to_side(fr_r[FRONT_N-1]);
      mg_side_r  <= mul_side_r;
      mg_sum_r   <= mg_sum_nxt;
      mg_d_r     <= mg_d_nxt;
      rnd_side_r <= rnd_side_nxt;
      rnd_sq_r   <= mg_sum_r[SQ_IN_W-1:0];
      sq_side_r[0] <= rnd_side_r;
      for (int k = 1; k < ROOT_W; k++) begin
        sq_side_r[k] <= sq_side_r[k-1];
      end
      dv_side_r[0] <= dv_in_side;
      for (int k = 1; k < QB; k++) begin
        dv_side_r[k] <= dv_side_r[k-1];
      end
      out_valid_r   <= dv_side_r[QB-1].valid;
      out_r_r       <= out_r_nxt;
      out_written_r <= out_written_nxt;
      out_status_r  <= out_status_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_r_x     = out_r_r[0];
  assign out_r_y     = out_r_r[1];
  assign out_r_z     = out_r_r[2];
  assign out_r_w     = out_r_r[3];
  assign out_written = out_written_r;
  assign out_status  = out_status_r;

`ifndef SYNTHESIS
  // a word that was not written carries no result
  a_unwritten_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_written) |->
      (out_r_x == 0 && out_r_y == 0 && out_r_z == 0 && out_r_w == 0))
    else $error("unwritten word carries a non-zero result");

  // zero-length normalise is written and gives zeros
  a_zero_norm : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_ZERO_NORM) |->
      (out_written && out_r_x == 0 && out_r_y == 0 && out_r_z == 0 && out_r_w == 0))
    else $error("zero-length normalise word malformed");

  // cross width error is never written
  a_cross_w : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_CROSS_W) |-> !out_written)
    else $error("cross width error flagged on a written word");

  // a held output word freezes the pipe
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(dv_side_r[QB-1]) && out_valid))
    else $error("pipe moved while output held");
`endif

endmodule
